// File: hdl/rscc_pkg.sv
`timescale 1ns / 1ps

package rscc_pkg;

    // Store sides; one memory word holds one row of pixels.
    localparam int MAX_GRID  = 32;
    localparam int MAX_STAMP = 32;
    localparam int ROW_AW    = $clog2(MAX_GRID);
    localparam int SIZE_W    = 6;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD_TARGET = 2'd0;
    localparam logic [1:0] OP_LOAD_STAMP  = 2'd1;
    localparam logic [1:0] OP_CHECK       = 2'd2;

    // Configuration register indexes.
    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_STAMP_SIZE = 1'b1;

    typedef logic [MAX_GRID-1:0] row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_clear;
        logic clear_row;
        logic init_scan;
        logic step_i;
        logic rewind_i;
        logic paint_row;
        logic next_place;
        logic init_cmp;
        logic cmp_row;
        logic emit;
    } rscc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_last_clear;
        logic i_last_k;
        logic i_last_n;
        logic fit_bad;
        logic place_last;
        logic skip_scan;
        logic grid_zero;
        logic out_busy;
    } rscc_sts_t;

endpackage

// File: hdl/rscc_ctrl.sv
`timescale 1ns / 1ps

module rscc_ctrl
    import rscc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] operation,
    output logic       in_stall,
    input  rscc_sts_t  sts,
    output rscc_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_FIT_RD   = 4'd2;
    localparam logic [3:0] ST_FIT_CHK  = 4'd3;
    localparam logic [3:0] ST_PAINT_RD = 4'd4;
    localparam logic [3:0] ST_PAINT_WR = 4'd5;
    localparam logic [3:0] ST_CMP_RD   = 4'd6;
    localparam logic [3:0] ST_CMP_CHK  = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Sequencing of clear, fit test, paint and final compare.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && operation == OP_CHECK)
                begin
                    cmd.init_clear = 1'b1;
                    state_next     = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (!sts.i_last_clear)
                begin
                    cmd.step_i = 1'b1;
                end
                else if (sts.grid_zero)
                begin
                    cmd.init_cmp = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (sts.skip_scan)
                begin
                    cmd.init_cmp = 1'b1;
                    state_next   = ST_CMP_RD;
                end
                else
                begin
                    cmd.init_scan = 1'b1;
                    state_next    = ST_FIT_RD;
                end
            end
            ST_FIT_RD:
            begin
                state_next = ST_FIT_CHK;
            end
            ST_FIT_CHK:
            begin
                if (sts.fit_bad)
                begin
                    if (sts.place_last)
                    begin
                        cmd.init_cmp = 1'b1;
                        state_next   = ST_CMP_RD;
                    end
                    else
                    begin
                        cmd.next_place = 1'b1;
                        state_next     = ST_FIT_RD;
                    end
                end
                else if (sts.i_last_k)
                begin
                    cmd.rewind_i = 1'b1;
                    state_next   = ST_PAINT_RD;
                end
                else
                begin
                    cmd.step_i = 1'b1;
                    state_next = ST_FIT_RD;
                end
            end
            ST_PAINT_RD:
            begin
                state_next = ST_PAINT_WR;
            end
            ST_PAINT_WR:
            begin
                cmd.paint_row = 1'b1;
                if (!sts.i_last_k)
                begin
                    cmd.step_i = 1'b1;
                    state_next = ST_PAINT_RD;
                end
                else if (sts.place_last)
                begin
                    cmd.init_cmp = 1'b1;
                    state_next   = ST_CMP_RD;
                end
                else
                begin
                    cmd.next_place = 1'b1;
                    state_next     = ST_FIT_RD;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                cmd.cmp_row = 1'b1;
                if (sts.i_last_n)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step_i = 1'b1;
                    state_next = ST_CMP_RD;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/rscc_datapath.sv
`timescale 1ns / 1ps

module rscc_datapath
    import rscc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic              pixel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              covers_exactly,
    input  rscc_cmd_t         cmd,
    output rscc_sts_t         sts
);

    // Row-wide memories; the stamp is kept both by rows and by columns.
    row_t tgt_mem  [MAX_GRID];
    row_t cvs_mem  [MAX_GRID];
    row_t srow_mem [MAX_STAMP];
    row_t scol_mem [MAX_STAMP];

    logic [SIZE_W-1:0] grid_reg;
    logic [SIZE_W-1:0] stamp_reg;
    logic [SIZE_W-1:0] n_sz;
    logic [SIZE_W-1:0] k_sz;
    logic [SIZE_W-1:0] span;
    logic [SIZE_W-1:0] i_reg;
    logic [SIZE_W-1:0] x_reg;
    logic [SIZE_W-1:0] y_reg;
    logic [1:0]        rot_reg;
    logic              eq_reg;
    logic              out_valid_reg;
    logic              result_reg;
    row_t              tgt_rd_reg;
    row_t              cvs_rd_reg;
    row_t              srow_rd_reg;
    row_t              scol_rd_reg;
    logic [SIZE_W-1:0] row_sum;
    logic [SIZE_W-1:0] st_sum;
    logic [ROW_AW-1:0] row_addr;
    logic [ROW_AW-1:0] st_addr;
    row_t              st_word;
    row_t              st_rev;
    row_t              st_line;
    row_t              st_placed;
    row_t              mask_n;
    row_t              mask_k;
    logic              accept;

    assign accept = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg  <= SIZE_W'(1);
            stamp_reg <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_SIZE:  grid_reg  <= cfg_data;
                REG_STAMP_SIZE: stamp_reg <= cfg_data;
                default:        grid_reg  <= grid_reg;
            endcase
        end
    end

    // Sizes in use, saturated to the store sides.
    assign n_sz = (grid_reg > SIZE_W'(MAX_GRID)) ? SIZE_W'(MAX_GRID) : grid_reg;
    assign k_sz = (stamp_reg > SIZE_W'(MAX_STAMP)) ? SIZE_W'(MAX_STAMP) : stamp_reg;
    assign span = n_sz - k_sz;

    assign mask_n = ~({MAX_GRID{1'b1}} << n_sz);
    assign mask_k = ~({MAX_GRID{1'b1}} << k_sz);

    // Addresses: the grid row under the stamp, and the stamp line for the rotation.
    assign row_sum  = x_reg + i_reg;
    assign row_addr = row_sum[ROW_AW-1:0];
    assign st_sum   = rot_reg[1] ? (k_sz - SIZE_W'(1) - i_reg) : i_reg;
    assign st_addr  = st_sum[ROW_AW-1:0];

    // Pixel loads.
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD_TARGET)
        begin
            tgt_mem[row][col] <= pixel;
        end
        if (accept && operation == OP_LOAD_STAMP)
        begin
            srow_mem[row][col] <= pixel;
            scol_mem[col][row] <= pixel;
        end
    end

    // Registered reads.
    always_ff @(posedge clk)
    begin
        tgt_rd_reg  <= tgt_mem[row_addr];
        cvs_rd_reg  <= cvs_mem[row_addr];
        srow_rd_reg <= srow_mem[st_addr];
        scol_rd_reg <= scol_mem[st_addr];
    end

    // Canvas clearing and painting.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_row)
        begin
            cvs_mem[row_addr] <= '0;
        end
        else if (cmd.paint_row)
        begin
            cvs_mem[row_addr] <= cvs_rd_reg | st_placed;
        end
    end

    // Rotated stamp row: quarter and half turns read reversed within the stamp side.
    assign st_word = rot_reg[0] ? scol_rd_reg : srow_rd_reg;
    always_comb
    begin
        for (int b = 0; b < MAX_GRID; b++)
        begin
            st_rev[b] = st_word[MAX_GRID-1-b];
        end
    end
    assign st_line   = (rot_reg == 2'd1 || rot_reg == 2'd2)
                       ? (st_rev >> (SIZE_W'(MAX_GRID) - k_sz))
                       : (st_word & mask_k);
    assign st_placed = st_line << y_reg;

    // Loop counters and the compare flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
            rot_reg <= '0;
            eq_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.init_clear || cmd.init_cmp)
            begin
                i_reg <= '0;
                x_reg <= '0;
            end
            else if (cmd.init_scan)
            begin
                i_reg   <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
                rot_reg <= '0;
            end
            else if (cmd.next_place)
            begin
                i_reg <= '0;
                if (y_reg == span)
                begin
                    y_reg <= '0;
                    if (x_reg == span)
                    begin
                        x_reg   <= '0;
                        rot_reg <= rot_reg + 2'd1;
                    end
                    else
                    begin
                        x_reg <= x_reg + SIZE_W'(1);
                    end
                end
                else
                begin
                    y_reg <= y_reg + SIZE_W'(1);
                end
            end
            else if (cmd.rewind_i)
            begin
                i_reg <= '0;
            end
            else if (cmd.step_i)
            begin
                i_reg <= i_reg + SIZE_W'(1);
            end

            if (cmd.init_cmp)
            begin
                eq_reg <= 1'b1;
            end
            else if (cmd.cmp_row && (((cvs_rd_reg ^ tgt_rd_reg) & mask_n) != '0))
            begin
                eq_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= eq_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign covers_exactly = result_reg;

    // Status.
    assign sts.i_last_clear = (i_reg == SIZE_W'(MAX_GRID - 1));
    assign sts.i_last_k     = (i_reg == k_sz - SIZE_W'(1));
    assign sts.i_last_n     = (i_reg == n_sz - SIZE_W'(1));
    assign sts.fit_bad      = ((st_placed & ~tgt_rd_reg) != '0);
    assign sts.place_last   = (rot_reg == 2'd3) && (x_reg == span) && (y_reg == span);
    assign sts.skip_scan    = (k_sz == '0) || (k_sz > n_sz);
    assign sts.grid_zero    = (n_sz == '0);
    assign sts.out_busy     = out_valid_reg && out_stall;

endmodule

// File: hdl/rotated_stamp_cover_check.sv
`timescale 1ns / 1ps

// Rotated stamp cover check: binary opening of a square target by a square
// stamp and its four quarter-turn rotations.
// Input channel (in_valid / in_stall): one beat per pixel load, target or
// stamp, or one check beat. Loads are taken one per cycle while idle and
// give no result. A check beat gives one beat on the output channel
// (out_valid / out_stall) carrying covers_exactly.
// A check clears the canvas row by row over all MAX_GRID store rows, then for
// each rotation and placement tests the stamp rows against the target
// (stopping at the first miss) and paints them onto the canvas on a fit, then
// compares the grid rows and loads the result into the output register. Each
// row step is a registered read of the row-wide memories, then a test or write.
// in_stall is high throughout a check.
// The result sits in an output register; a stalled result is held, and a
// following check finishes its work but waits until that beat is taken.
// Reset sets both size registers to 1 and empties the output register;
// pixel stores are undefined until loaded. Configure sizes only while idle.
module rotated_stamp_cover_check
    import rscc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic              pixel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              covers_exactly
);

    rscc_cmd_t cmd;
    rscc_sts_t sts;

    rscc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rscc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .row            (row),
        .col            (col),
        .pixel          (pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .covers_exactly (covers_exactly),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// File: dv/rscc_cover_checker.sv
`timescale 1ns / 1ps

module rscc_cover_checker
    import rscc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic              pixel,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              covers_exactly,
    output int                fail_count,
    output int                pending
);

    // Mirror of the pixel stores, the canvas and the size registers.
    bit              target_px [MAX_GRID][MAX_GRID];
    bit              stamp_px  [MAX_STAMP][MAX_STAMP];
    bit              canvas_px [MAX_GRID][MAX_GRID];
    logic [SIZE_W-1:0] grid_reg;
    logic [SIZE_W-1:0] stamp_reg;
    bit              cover_queue [$];

    task automatic note_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Stamp pixel (i,j) after rot quarter turns, side k.
    function automatic bit turned_px(int rot, int i, int j, int k);
        case (rot)
            0: return stamp_px[i][j];
            1: return stamp_px[k-1-j][i];
            2: return stamp_px[k-1-i][k-1-j];
            default: return stamp_px[j][k-1-i];
        endcase
    endfunction

    // Paint every fitting rotated placement, then compare canvas to target.
    function automatic bit predict_cover();
        int  n;
        int  k;
        bit  fits;
        n = (grid_reg > MAX_GRID) ? MAX_GRID : int'(grid_reg);
        k = (stamp_reg > MAX_STAMP) ? MAX_STAMP : int'(stamp_reg);
        foreach (canvas_px[a, b])
            canvas_px[a][b] = 1'b0;
        if (k <= n)
        begin
            for (int rot = 0; rot < 4; rot++)
                for (int x = 0; x + k <= n; x++)
                    for (int y = 0; y + k <= n; y++)
                    begin
                        fits = 1'b1;
                        for (int i = 0; i < k; i++)
                            for (int j = 0; j < k; j++)
                                if (turned_px(rot, i, j, k) && !target_px[x+i][y+j])
                                    fits = 1'b0;
                        if (fits)
                            for (int i = 0; i < k; i++)
                                for (int j = 0; j < k; j++)
                                    if (turned_px(rot, i, j, k))
                                        canvas_px[x+i][y+j] = 1'b1;
                    end
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (canvas_px[i][j] != target_px[i][j])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Follow register writes, input beats and result beats.
    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            grid_reg  = SIZE_W'(1);
            stamp_reg = SIZE_W'(1);
            cover_queue.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_SIZE)
                    grid_reg = cfg_data;
                else
                    stamp_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                case (operation)
                    OP_LOAD_TARGET: target_px[row][col] = pixel;
                    OP_LOAD_STAMP:  stamp_px[row][col] = pixel;
                    OP_CHECK:       cover_queue.insert(cover_queue.size(), predict_cover());
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (cover_queue.size() == 0)
                    note_mismatch("result beat with nothing expected");
                else
                begin
                    want = cover_queue.pop_front();
                    if (covers_exactly !== want)
                        note_mismatch($sformatf("covers_exactly %b, expected %b",
                                                covers_exactly, want));
                end
            end
            pending <= cover_queue.size();
        end
    end

endmodule

// File: dv/tb_rotated_stamp_cover_check.sv
`timescale 1ns / 1ps

module tb_rotated_stamp_cover_check;
    import rscc_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         ITEM_GOAL  = 1250;
    localparam int         CHECK_GOAL = 20;
    localparam int         STUCK_MAX  = 300000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        operation;
    logic [4:0]        row;
    logic [4:0]        col;
    logic              pixel;
    logic              out_valid;
    logic              out_stall;
    logic              covers_exactly;
    int                fail_count;
    int                pending;

    int  items_sent;
    int  checks_sent;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cur_n;
    int  cur_k;
    int  stuck_cycles;
    bit  target_img [MAX_GRID][MAX_GRID];
    bit  stamp_img  [MAX_STAMP][MAX_STAMP];

    rotated_stamp_cover_check dut (.*);

    rscc_cover_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random back-pressure on the result channel.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: too long without any beat or register write ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one input beat, with random idle cycles ahead of it.
    task automatic send_beat(input logic [1:0] op, input int r, input int c, input bit px);
        if (items_sent < ITEM_GOAL / 3)
        begin
            send_idle_pct  = 23;
            recv_stall_pct = 78;
        end
        else if (items_sent < 2 * ITEM_GOAL / 3)
        begin
            send_idle_pct  = 78;
            recv_stall_pct = 23;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        row       <= r[4:0];
        col       <= c[4:0];
        pixel     <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
        if (op == OP_CHECK)
            checks_sent++;
    endtask

    // A pixel load, sometimes preceded by an ignored beat or a load outside the sizes.
    task automatic load_px(input logic [1:0] op, input int r, input int c, input bit px);
        if ($urandom_range(19) == 0)
            send_beat(OP_UNUSED, $urandom_range(31), $urandom_range(31),
                      1'($urandom_range(1)));
        if (cur_n < MAX_GRID && $urandom_range(19) == 0)
            send_beat(OP_LOAD_TARGET, $urandom_range(31, cur_n), $urandom_range(31),
                      1'($urandom_range(1)));
        send_beat(op, r, c, px);
    endtask

    task automatic send_check();
        send_beat(OP_CHECK, $urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
    endtask

    // Pause until every result is in and the block has gone quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_sizes(input int g, input int s);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_SIZE;
        cfg_data  <= g[SIZE_W-1:0];
        @(posedge clk);
        cfg_index <= REG_STAMP_SIZE;
        cfg_data  <= s[SIZE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_n = (g > MAX_GRID) ? MAX_GRID : g;
        cur_k = (s > MAX_STAMP) ? MAX_STAMP : s;
    endtask

    function automatic bit turned_img(int rot, int i, int j, int k);
        case (rot)
            0: return stamp_img[i][j];
            1: return stamp_img[k-1-j][i];
            2: return stamp_img[k-1-i][k-1-j];
            default: return stamp_img[j][k-1-i];
        endcase
    endfunction

    // One case: set sizes, load a stamp and a target, then a few checks with edits between.
    task automatic run_cover_case(input int g, input int s);
        int dens;
        int rot;
        int x;
        int y;
        int fr;
        int fc;
        set_sizes(g, s);
        dens = $urandom_range(100);
        for (int i = 0; i < cur_k; i++)
            for (int j = 0; j < cur_k; j++)
                stamp_img[i][j] = ($urandom_range(99) < dens);
        // Mostly a union of rotated placements, so that full covers occur.
        if (cur_k > 0 && cur_k <= cur_n && $urandom_range(2) != 0)
        begin
            foreach (target_img[a, b])
                target_img[a][b] = 1'b0;
            repeat ($urandom_range(1, 3))
            begin
                rot = $urandom_range(3);
                x   = $urandom_range(cur_n - cur_k);
                y   = $urandom_range(cur_n - cur_k);
                for (int i = 0; i < cur_k; i++)
                    for (int j = 0; j < cur_k; j++)
                        if (turned_img(rot, i, j, cur_k))
                            target_img[x+i][y+j] = 1'b1;
            end
        end
        else
        begin
            dens = $urandom_range(100);
            for (int i = 0; i < cur_n; i++)
                for (int j = 0; j < cur_n; j++)
                    target_img[i][j] = ($urandom_range(99) < dens);
        end
        for (int i = 0; i < cur_k; i++)
            for (int j = 0; j < cur_k; j++)
                load_px(OP_LOAD_STAMP, i, j, stamp_img[i][j]);
        for (int i = 0; i < cur_n; i++)
            for (int j = 0; j < cur_n; j++)
                load_px(OP_LOAD_TARGET, i, j, target_img[i][j]);
        repeat ($urandom_range(1, 3))
        begin
            send_check();
            if (cur_n > 0 && $urandom_range(1) == 0)
            begin
                fr = $urandom_range(cur_n - 1);
                fc = $urandom_range(cur_n - 1);
                target_img[fr][fc] = !target_img[fr][fc];
                load_px(OP_LOAD_TARGET, fr, fc, target_img[fr][fc]);
            end
        end
    endtask

    initial
    begin
        int g;
        int s;
        int seq;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_GRID_SIZE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        operation      = OP_LOAD_TARGET;
        row            = '0;
        col            = '0;
        pixel          = 1'b0;
        out_stall      = 1'b0;
        stuck_cycles   = 0;
        items_sent     = 0;
        checks_sent    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_n          = 1;
        cur_k          = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-pixel grid and stamp at reset sizes.
        send_beat(OP_LOAD_TARGET, 0, 0, 1'b1);
        send_beat(OP_LOAD_STAMP, 0, 0, 1'b1);
        send_check();
        send_beat(OP_LOAD_TARGET, 0, 0, 1'b0);
        send_check();
        send_beat(OP_LOAD_TARGET, 0, 0, 1'b1);
        send_beat(OP_LOAD_STAMP, 0, 0, 1'b0);
        send_check();
        send_beat(OP_UNUSED, 31, 31, 1'b1);
        send_beat(OP_LOAD_TARGET, 31, 31, 1'b1);
        send_beat(OP_LOAD_STAMP, 31, 31, 1'b1);
        send_check();
        // Zero grid, zero stamp, and a stamp larger than the grid.
        set_sizes(0, 1);
        send_check();
        set_sizes(1, 0);
        send_check();
        set_sizes(1, 2);
        send_check();
        // Stamp size above the store side saturates.
        set_sizes(1, 40);
        send_check();

        // Random cases, mostly small, with one at the largest grid.
        seq = 0;
        while (items_sent < ITEM_GOAL || checks_sent < CHECK_GOAL)
        begin
            if (seq == 6)
                run_cover_case(63, 3);
            else
            begin
                case ($urandom_range(9))
                    0:       g = 0;
                    default: g = $urandom_range(1, 6);
                endcase
                case ($urandom_range(7))
                    0:       s = 0;
                    1:       s = g + 1;
                    default: s = (g == 0) ? $urandom_range(1) : $urandom_range(1, g);
                endcase
                run_cover_case(g, s);
            end
            seq++;
        end

        // Drain the remaining results.
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/rscc_pkg.sv
hdl/rscc_ctrl.sv
hdl/rscc_datapath.sv
hdl/rotated_stamp_cover_check.sv
dv/rscc_cover_checker.sv
dv/tb_rotated_stamp_cover_check.sv
